// ----- rtl/lpkm_pkg.sv -----
// ----------------------------------------------------------------------------
// lpkm_pkg
// Shared types and constants of the linear-probing key map.
// ----------------------------------------------------------------------------
`default_nettype none

package lpkm_pkg;

  localparam int unsigned KEY_W       = 31;
  localparam int unsigned ETYPE_W     = 2;
  localparam int unsigned EVALUE_W    = 32;
  localparam int unsigned LIMIT_W     = 7;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 40;
  localparam logic [31:0] HASH_MUL    = 32'd2654435761;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd44;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    RES_NONE       = 2'd0,
    RES_TYPE_VALUE = 2'd1,
    RES_VALUE      = 2'd2
  } res_sel_e;

  typedef enum logic [2:0] {
    S_BOOT_CLR = 3'd0,
    S_IDLE     = 3'd1,
    S_READ     = 3'd2,
    S_CHECK    = 3'd3,
    S_OP_CLR   = 3'd4
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [ETYPE_W-1:0]  etype;
    logic [EVALUE_W-1:0] evalue;
    slot_e               status;
  } slot_t;

  typedef struct packed {
    logic     idle;
    logic     load;
    logic     clr_start;
    logic     clr_write;
    logic     rd_en;
    logic     advance;
    logic     rec_tomb;
    logic     wr_insert;
    logic     wr_tomb;
    logic     post;
    status_e  res_status;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic  in_valid;
    kind_e kind;
    logic  full;
    logic  out_free;
    logic  slot_empty;
    logic  slot_hit;
    logic  slot_tomb;
    logic  have_tomb;
    logic  last_probe;
    logic  last_slot;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/linear_probe_key_map.sv -----
// ----------------------------------------------------------------------------
// linear_probe_key_map
// Open-addressing key map with linear probing and tombstones over a
// power-of-two slot RAM; insert, lookup, remove and clear.
//
//   channel   | direction | tdata (low bit up)                     | tuser
//   s_axis    | in        | key[30:0] type[32:31] value[64:33]     | kind
//   m_axis    | out       | status[1:0] type[3:2] value[35:4]      | -
//   cfg       | in        | load_limit[6:0]                        | -
//
// An item is accepted, then each slot probed, from the home position on and
// up to BUCKETS slots, takes a RAM read and then a compare. A full-table
// insert answers without reading the RAM. Clear writes one slot per cycle,
// the last one only once the result register is free.
// After reset the slot RAM is swept to empty with s_axis_tready_o low.
// A stalled result holds the block at its next compare or posting step.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_key_map #(
  parameter int unsigned BUCKETS = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output      logic                            s_axis_tready_o,
  // key[30:0], entry_type[32:31], entry_value[64:33], zero pad
  input  wire logic [lpkm_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind[1:0]
  input  wire logic [lpkm_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output      logic                            m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // status[1:0], found_type[3:2], found_value[35:4], zero pad
  output      logic [lpkm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [lpkm_pkg::LIMIT_W-1:0]    cfg_data_i
);
  import lpkm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lpkm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lpkm_dp #(
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire

// ----- rtl/lpkm_ram.sv -----
// ----------------------------------------------------------------------------
// lpkm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpkm_ram #(
  parameter int unsigned WIDTH = 67,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpkm_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpkm_ctrl
// Sequencer for the key map: boot sweep, probe loop, clear sweep, result post.
// ----------------------------------------------------------------------------
`default_nettype none

module lpkm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lpkm_pkg::dp_stat_t stat_i,
  output      lpkm_pkg::dp_cmd_t  cmd_o
);
  import lpkm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_OK;
    cmd_o.res_sel    = RES_NONE;
    case (state_q)
      S_BOOT_CLR: begin
        cmd_o.clr_write = 1'b1;
        if (stat_i.last_slot) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.idle = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.kind == KIND_CLEAR) begin
          cmd_o.clr_start = 1'b1;
          state_d         = S_OP_CLR;
        end else if (stat_i.kind == KIND_INSERT && stat_i.full) begin
          if (stat_i.out_free) begin
            cmd_o.post       = 1'b1;
            cmd_o.res_status = ST_FULL;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.out_free) begin
          case (stat_i.kind)
            KIND_INSERT: begin
              if (stat_i.slot_empty) begin
                cmd_o.wr_insert = 1'b1;
                cmd_o.post      = 1'b1;
                state_d         = S_IDLE;
              end else if (stat_i.slot_hit) begin
                cmd_o.post       = 1'b1;
                cmd_o.res_status = ST_DUP;
                state_d          = S_IDLE;
              end else begin
                cmd_o.rec_tomb = stat_i.slot_tomb && !stat_i.have_tomb;
                if (stat_i.last_probe) begin
                  cmd_o.post = 1'b1;
                  state_d    = S_IDLE;
                  if (stat_i.have_tomb || stat_i.slot_tomb) begin
                    cmd_o.wr_insert = 1'b1;
                  end else begin
                    cmd_o.res_status = ST_FULL;
                  end
                end else begin
                  cmd_o.advance = 1'b1;
                  state_d       = S_READ;
                end
              end
            end
            KIND_LOOKUP, KIND_REMOVE: begin
              if (stat_i.slot_hit) begin
                cmd_o.post = 1'b1;
                state_d    = S_IDLE;
                if (stat_i.kind == KIND_REMOVE) begin
                  cmd_o.wr_tomb = 1'b1;
                  cmd_o.res_sel = RES_VALUE;
                end else begin
                  cmd_o.res_sel = RES_TYPE_VALUE;
                end
              end else if (stat_i.slot_empty || stat_i.last_probe) begin
                cmd_o.post       = 1'b1;
                cmd_o.res_status = ST_MISS;
                state_d          = S_IDLE;
              end else begin
                cmd_o.advance = 1'b1;
                state_d       = S_READ;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_OP_CLR: begin
        if (!stat_i.last_slot) begin
          cmd_o.clr_write = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.clr_write = 1'b1;
          cmd_o.post      = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_BOOT_CLR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/lpkm_dp.sv -----
// ----------------------------------------------------------------------------
// lpkm_dp
// Datapath: operand registers, home-slot hash, probe pointer, slot RAM,
// occupancy counters, load limit register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpkm_dp #(
  parameter int unsigned BUCKETS = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire lpkm_pkg::dp_cmd_t                   cmd_i,
  output      lpkm_pkg::dp_stat_t                  stat_o,
  input  wire logic                                s_tvalid_i,
  output      logic                                s_tready_o,
  input  wire logic [lpkm_pkg::IN_DATA_W-1:0]      s_tdata_i,
  input  wire logic [lpkm_pkg::IN_USER_W-1:0]      s_tuser_i,
  output      logic                                m_tvalid_o,
  input  wire logic                                m_tready_i,
  output      logic [lpkm_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [lpkm_pkg::LIMIT_W-1:0]        cfg_data_i
);
  import lpkm_pkg::*;

  localparam int unsigned IW = $clog2(BUCKETS);
  localparam int unsigned CW = $clog2(BUCKETS + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned LW = (SW > LIMIT_W) ? SW : LIMIT_W;

  kind_e                kind_q;
  logic [KEY_W-1:0]     key_q;
  logic [ETYPE_W-1:0]   etype_q;
  logic [EVALUE_W-1:0]  evalue_q;
  logic [IW-1:0]        idx_q;
  logic [IW-1:0]        n_q;
  logic [IW-1:0]        target_q;
  logic                 have_tomb_q;
  logic                 full_q;
  logic [CW-1:0]        live_q;
  logic [CW-1:0]        tomb_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [2*IW-1:0]      hash_prod;
  logic [IW-1:0]        home;
  logic [SW-1:0]        occ_sum;
  logic                 out_free;
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  slot_t                ram_wdata;
  slot_t                rd_slot;
  logic [EVALUE_W-1:0]  res_value;
  logic [ETYPE_W-1:0]   res_type;

  assign hash_prod = (2*IW)'(s_tdata_i[IW-1:0]) * (2*IW)'(HASH_MUL[IW-1:0]);
  assign home      = hash_prod[IW-1:0];
  assign occ_sum   = SW'(live_q) + SW'(tomb_q);
  assign out_free  = !out_valid_q || m_tready_i;

  assign s_tready_o  = cmd_i.idle;
  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o  = out_valid_q;
  assign m_tdata_o   = out_data_q;

  assign stat_o.in_valid   = s_tvalid_i;
  assign stat_o.kind       = kind_q;
  assign stat_o.full       = full_q;
  assign stat_o.out_free   = out_free;
  assign stat_o.slot_empty = rd_slot.status == SLOT_EMPTY;
  assign stat_o.slot_hit   = rd_slot.status == SLOT_LIVE && rd_slot.key == key_q;
  assign stat_o.slot_tomb  = rd_slot.status == SLOT_TOMB;
  assign stat_o.have_tomb  = have_tomb_q;
  assign stat_o.last_probe = n_q == {IW{1'b1}};
  assign stat_o.last_slot  = idx_q == {IW{1'b1}};

  always_comb begin
    ram_we    = cmd_i.clr_write || cmd_i.wr_insert || cmd_i.wr_tomb;
    ram_waddr = (cmd_i.wr_insert && have_tomb_q) ? target_q : idx_q;
    ram_wdata = '0;
    ram_wdata.status = SLOT_EMPTY;
    if (cmd_i.wr_insert) begin
      ram_wdata.key    = key_q;
      ram_wdata.etype  = etype_q;
      ram_wdata.evalue = evalue_q;
      ram_wdata.status = SLOT_LIVE;
    end else if (cmd_i.wr_tomb) begin
      ram_wdata.key    = rd_slot.key;
      ram_wdata.etype  = rd_slot.etype;
      ram_wdata.status = SLOT_TOMB;
    end
  end

  lpkm_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (BUCKETS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_slot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_e'(s_tuser_i);
      key_q    <= s_tdata_i[KEY_W-1:0];
      etype_q  <= s_tdata_i[KEY_W+ETYPE_W-1:KEY_W];
      evalue_q <= s_tdata_i[KEY_W+ETYPE_W+EVALUE_W-1:KEY_W+ETYPE_W];
      full_q   <= LW'(occ_sum) >= LW'(limit_q);
    end
    if (cmd_i.load || cmd_i.advance) begin
      n_q <= cmd_i.load ? '0 : n_q + IW'(1);
    end
    if (cmd_i.rec_tomb) begin
      target_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      have_tomb_q <= 1'b0;
      live_q      <= '0;
      tomb_q      <= '0;
      limit_q     <= LIMIT_RESET;
    end else begin
      if (cmd_i.load) begin
        idx_q       <= home;
        have_tomb_q <= 1'b0;
      end else if (cmd_i.clr_start) begin
        idx_q <= '0;
      end else if (cmd_i.advance || cmd_i.clr_write) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.rec_tomb) begin
        have_tomb_q <= 1'b1;
      end
      if (cmd_i.clr_start) begin
        live_q <= '0;
        tomb_q <= '0;
      end else if (cmd_i.wr_insert) begin
        live_q <= live_q + CW'(1);
        tomb_q <= tomb_q - CW'(have_tomb_q || rd_slot.status == SLOT_TOMB);
      end else if (cmd_i.wr_tomb) begin
        live_q <= live_q - CW'(1);
        tomb_q <= tomb_q + CW'(1);
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    res_type  = '0;
    res_value = '0;
    case (cmd_i.res_sel)
      RES_TYPE_VALUE: begin
        res_type  = rd_slot.etype;
        res_value = rd_slot.evalue;
      end
      RES_VALUE: begin
        res_value = rd_slot.evalue;
      end
      default: begin
        res_type  = '0;
        res_value = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.post) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      out_data_q <= OUT_DATA_W'({res_value, res_type, cmd_i.res_status});
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpkm_checker.sv -----
// ----------------------------------------------------------------------------
// lpkm_checker
// Port-level checks on the key map, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpkm_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid_i,
  input wire logic                            s_axis_tready_o,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [lpkm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import lpkm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item accepted while previous item in flight");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != ST_OK |-> m_axis_tdata_o[35:2] == '0)
    else $error("nonzero found fields on failed operation");

  a_boot_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready_o && !m_axis_tvalid_o)
    else $error("ready or result right after reset");

endmodule

bind linear_probe_key_map lpkm_checker u_lpkm_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_probe_key_map. Drives insert, lookup, remove
// and clear items in random bursts over pools of colliding keys, walks the
// load limit through several values between phases, and compares each result
// against a mirror of the slot table that is kept in step with accepted items.
// ----------------------------------------------------------------------------
module tb;

  import lpkm_pkg::*;

  typedef struct packed {
    status_e           status;
    logic [ETYPE_W-1:0]  ftype;
    logic [EVALUE_W-1:0] fvalue;
  } reply_t;

  class key_map_mirror;
    localparam int SLOTS = 64;

    slot_e               state_of[SLOTS];
    logic [KEY_W-1:0]    key_of[SLOTS];
    logic [ETYPE_W-1:0]  type_of[SLOTS];
    logic [EVALUE_W-1:0] value_of[SLOTS];
    int                  live;
    int                  tombs;
    int                  limit;
    int                  failures;
    reply_t              replies[$];

    function new();
      limit    = int'(LIMIT_RESET);
      failures = 0;
      wipe();
    endfunction

    static function int home_of(logic [KEY_W-1:0] key);
      logic [31:0] h;
      h = {1'b0, key} * HASH_MUL;
      return int'(h) & (SLOTS - 1);
    endfunction

    function void wipe();
      for (int i = 0; i < SLOTS; i++) begin
        state_of[i] = SLOT_EMPTY;
        key_of[i]   = '0;
        type_of[i]  = '0;
        value_of[i] = '0;
      end
      live  = 0;
      tombs = 0;
    endfunction

    function void set_limit(int v);
      limit = v;
    endfunction

    function int outstanding();
      return replies.size();
    endfunction

    function int find_live(logic [KEY_W-1:0] key);
      int idx;
      idx = home_of(key);
      for (int n = 0; n < SLOTS; n++) begin
        if (state_of[idx] == SLOT_EMPTY) return -1;
        if (state_of[idx] == SLOT_LIVE && key_of[idx] == key) return idx;
        idx = (idx + 1) & (SLOTS - 1);
      end
      return -1;
    endfunction

    function void note_request(kind_e kind, logic [KEY_W-1:0] key,
                               logic [ETYPE_W-1:0] etype, logic [EVALUE_W-1:0] evalue);
      reply_t r;
      int     idx;
      int     spot;
      bit     seen_tomb;
      bit     dup;
      r.status = ST_OK;
      r.ftype  = '0;
      r.fvalue = '0;
      case (kind)
        KIND_INSERT: begin
          if (live + tombs >= limit) begin
            r.status = ST_FULL;
          end else begin
            spot      = -1;
            seen_tomb = 1'b0;
            dup       = 1'b0;
            idx       = home_of(key);
            for (int n = 0; n < SLOTS; n++) begin
              if (state_of[idx] == SLOT_EMPTY) begin
                spot = idx;
                break;
              end
              if (state_of[idx] == SLOT_TOMB) begin
                if (!seen_tomb) begin
                  seen_tomb = 1'b1;
                  spot      = idx;
                end
              end else if (key_of[idx] == key) begin
                dup = 1'b1;
                break;
              end
              idx = (idx + 1) & (SLOTS - 1);
            end
            if (dup) begin
              r.status = ST_DUP;
            end else if (spot < 0) begin
              r.status = ST_FULL;
            end else begin
              if (state_of[spot] == SLOT_TOMB) tombs--;
              state_of[spot] = SLOT_LIVE;
              key_of[spot]   = key;
              type_of[spot]  = etype;
              value_of[spot] = evalue;
              live++;
            end
          end
        end
        KIND_LOOKUP: begin
          idx = find_live(key);
          if (idx >= 0) begin
            r.ftype  = type_of[idx];
            r.fvalue = value_of[idx];
          end else begin
            r.status = ST_MISS;
          end
        end
        KIND_REMOVE: begin
          idx = find_live(key);
          if (idx >= 0) begin
            r.fvalue      = value_of[idx];
            state_of[idx] = SLOT_TOMB;
            value_of[idx] = '0;
            live--;
            tombs++;
          end else begin
            r.status = ST_MISS;
          end
        end
        default: wipe();
      endcase
      replies.push_back(r);
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] data);
      reply_t want;
      if (replies.size() == 0) begin
        if (failures < 10) $display("result with no pending item: %h", data);
        failures++;
        return;
      end
      want = replies.pop_front();
      if (data[1:0] !== want.status || data[3:2] !== want.ftype ||
          data[35:4] !== want.fvalue) begin
        if (failures < 10)
          $display("mismatch: expected status %0d type %0d value %h, got %0d %0d %h",
                   want.status, want.ftype, want.fvalue, data[1:0], data[3:2], data[35:4]);
        failures++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [LIMIT_W-1:0]    cfg_data_i = '0;

  key_map_mirror sb = new();

  logic [KEY_W-1:0] key_pool[64];
  int               pool_len;
  int               stall_mode = 0;
  int               stall_left = 0;
  int               phase_limit[8] = '{64, 16, 1, 63, 2, 44, 0, 64};
  logic [KEY_W-1:0] ka, kb, kc;

  linear_probe_key_map u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_reply(m_axis_tdata_o);
  end

  function automatic logic [KEY_W-1:0] key_near(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] cand;
    cand = KEY_W'($urandom);
    while (key_map_mirror::home_of(cand) != key_map_mirror::home_of(key) || cand == key)
      cand++;
    return cand;
  endfunction

  task automatic send_item(kind_e kind, logic [KEY_W-1:0] key,
                           logic [ETYPE_W-1:0] etype, logic [EVALUE_W-1:0] evalue);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {7'd0, evalue, etype, key};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(kind, key, etype, evalue);
  endtask

  task automatic write_limit(int v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[LIMIT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic settle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic build_pool();
    int r;
    pool_len = $urandom_range(8, 64);
    for (int i = 0; i < pool_len; i++) begin
      r = $urandom_range(0, 19);
      if (i % 2 == 1 && r < 16) key_pool[i] = key_near(key_pool[i - 1]);
      else if (r == 0)          key_pool[i] = '0;
      else if (r == 1)          key_pool[i] = '1;
      else                      key_pool[i] = KEY_W'($urandom);
    end
  endtask

  task automatic run_random(int count);
    int               left;
    int               burst;
    int               gap;
    int               r;
    kind_e            kind;
    logic [KEY_W-1:0] key;
    logic [EVALUE_W-1:0] value;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && left > 0; b++) begin
        r = $urandom_range(0, 99);
        if (r < 42)      kind = KIND_INSERT;
        else if (r < 70) kind = KIND_LOOKUP;
        else if (r < 97) kind = KIND_REMOVE;
        else             kind = KIND_CLEAR;
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_len - 1)];
        else                             key = KEY_W'($urandom);
        r = $urandom_range(0, 19);
        if (r == 0)      value = '0;
        else if (r == 1) value = '1;
        else             value = $urandom;
        send_item(kind, key, ETYPE_W'($urandom_range(0, 3)), value);
        left--;
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    ka = KEY_W'($urandom);
    kb = key_near(ka);
    kc = key_near(ka);
    while (kc == kb) kc = key_near(ka);

    send_item(KIND_INSERT, '0, 2'd0, '0);
    send_item(KIND_INSERT, '1, 2'd3, '1);
    send_item(KIND_INSERT, '0, 2'd1, 32'd5);
    send_item(KIND_LOOKUP, '0, 2'd0, '0);
    send_item(KIND_LOOKUP, '1, 2'd0, '0);
    send_item(KIND_LOOKUP, ka, 2'd0, '0);
    send_item(KIND_REMOVE, '1, 2'd0, '0);
    send_item(KIND_LOOKUP, '1, 2'd0, '0);
    send_item(KIND_REMOVE, '1, 2'd0, '0);
    send_item(KIND_INSERT, ka, 2'd2, $urandom);
    send_item(KIND_INSERT, kb, 2'd1, $urandom);
    send_item(KIND_INSERT, kc, 2'd3, $urandom);
    send_item(KIND_REMOVE, ka, 2'd0, '0);
    send_item(KIND_LOOKUP, kc, 2'd0, '0);
    send_item(KIND_INSERT, ka, 2'd0, $urandom);
    send_item(KIND_LOOKUP, ka, 2'd0, '0);
    send_item(KIND_CLEAR, '0, 2'd0, '0);
    send_item(KIND_LOOKUP, kb, 2'd0, '0);
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    settle();

    write_limit(1);
    send_item(KIND_INSERT, ka, 2'd1, $urandom);
    send_item(KIND_INSERT, ka, 2'd2, $urandom);
    send_item(KIND_REMOVE, ka, 2'd0, '0);
    send_item(KIND_INSERT, kb, 2'd3, $urandom);
    send_item(KIND_LOOKUP, ka, 2'd0, '0);
    send_item(KIND_CLEAR, '0, 2'd0, '0);
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      settle();
      write_limit(phase_limit[p] == 0 ? $urandom_range(1, 64) : phase_limit[p]);
      build_pool();
      run_random(228);
    end

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
